// ===== design/cfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfrc_pkg
// Shared types and constants for the framed response checker: header layout,
// result codes and the beat carried from the parser to the output register.
// ----------------------------------------------------------------------------
package cfrc_pkg;

  localparam int unsigned HdrBytes = 8;
  localparam int unsigned PosWidth = 17;

  localparam logic [7:0]  ProcCode = 8'h6E;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  // header byte positions
  localparam logic [2:0] HdrPosProc   = 3'd0;
  localparam logic [2:0] HdrPosStatus = 3'd1;
  localparam logic [2:0] HdrPosCmd    = 3'd3;
  localparam logic [2:0] HdrPosLenHi  = 3'd4;
  localparam logic [2:0] HdrPosLenLo  = 3'd5;
  localparam logic [2:0] HdrPosCrcHi  = 3'd6;
  localparam logic [2:0] HdrPosCrcLo  = 3'd7;

  typedef enum logic [2:0] {
    RES_OK           = 3'd0,
    RES_BAD_PROC     = 3'd1,
    RES_CAM_ERR      = 3'd2,
    RES_CMD_MISMATCH = 3'd3,
    RES_HDR_CRC      = 3'd4,
    RES_PKT_CRC      = 3'd5
  } res_code_e;

  typedef struct packed {
    logic        vld;
    logic [7:0]  data;
    res_code_e   code;
    logic [7:0]  cam;
    logic [15:0] len;
    logic        last;
  } res_t;

endpackage

// ===== design/crc_framed_response_checker.sv =====
// an accepted byte is held in the input register; when the result register is empty or
// not stalled, the byte's result, if it has one, is loaded there and out_valid_o rises
// throughput: one byte per cycle unless out_stall_i holds a result; the byte-wide crc
// update and checks lie between the input register and the result register
// reset: asynchronous, clears the packet state, expected command and both valids
// ----------------------------------------------------------------------------
// crc_framed_response_checker
// Checks a framed response (header, payload, crc-16 trailer) byte by byte,
// streams payload beats and ends each packet with one status beat.
// ----------------------------------------------------------------------------
module crc_framed_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  result_code_o,
  output logic [7:0]  camera_code_o,
  output logic [15:0] payload_length_o,
  output logic        last_o
);

  logic           in_vld_q;
  logic [7:0]     in_byte_q;
  logic [7:0]     exp_cmd_q;
  logic           advance;
  logic           in_take;
  logic           out_vld_q, out_vld_d;
  cfrc_pkg::res_t res;
  cfrc_pkg::res_t out_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;

  cfrc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .exp_cmd_i (exp_cmd_q),
    .res_o     (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && res.vld) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      exp_cmd_q <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        exp_cmd_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res.vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign data_byte_o      = out_q.data;
  assign result_code_o    = out_q.code;
  assign camera_code_o    = out_q.cam;
  assign payload_length_o = out_q.len;
  assign last_o           = out_q.last;

endmodule

// ===== design/cfrc_crc16.sv =====
// ----------------------------------------------------------------------------
// cfrc_crc16
// One-byte update of a CRC-16 with polynomial 0x1021, msb first, no reflection.
// ----------------------------------------------------------------------------
module cfrc_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ cfrc_pkg::CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ===== design/cfrc_parser.sv =====
// ----------------------------------------------------------------------------
// cfrc_parser
// Packet state: tracks the byte position, captures header fields, runs the
// header checks and the trailer crc compare, and forms a result for each payload byte and one status result per packet.
// ----------------------------------------------------------------------------
module cfrc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          exp_cmd_i,
  output cfrc_pkg::res_t      res_o
);

  logic [cfrc_pkg::PosWidth-1:0] pos_q, pos_d, pay_end;
  logic        proc_ok_q, proc_ok_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] hdr_crc_q, hdr_crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic [15:0] got;
  logic        final_en;

  cfrc_crc16 u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign pay_end = cfrc_pkg::PosWidth'(cfrc_pkg::HdrBytes) + {1'b0, len_q};
  assign got     = {crc_hi_q, byte_i};

  always_comb begin
    cfrc_pkg::res_code_e code;
    code       = cfrc_pkg::RES_OK;
    final_en   = 1'b0;
    pos_d      = pos_q;
    proc_ok_d  = proc_ok_q;
    status_d   = status_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    hdr_crc_d  = hdr_crc_q;
    crc_hi_d   = crc_hi_q;
    crc_d      = crc_q;
    res_o      = '0;
    res_o.code = cfrc_pkg::RES_OK;

    if (step_i) begin
      pos_d = cfrc_pkg::PosWidth'(pos_q + 1'b1);
      if (pos_q < cfrc_pkg::PosWidth'(cfrc_pkg::HdrBytes)) begin
        crc_d = crc_next;
        case (pos_q[2:0])
          cfrc_pkg::HdrPosProc:   proc_ok_d = (byte_i == cfrc_pkg::ProcCode);
          cfrc_pkg::HdrPosStatus: status_d  = byte_i;
          cfrc_pkg::HdrPosCmd:    cmd_d     = byte_i;
          cfrc_pkg::HdrPosLenHi:  len_d     = {byte_i, 8'h00};
          cfrc_pkg::HdrPosLenLo: begin
            len_d     = {len_q[15:8], byte_i};
            hdr_crc_d = crc_next;
          end
          cfrc_pkg::HdrPosCrcHi:  crc_hi_d  = byte_i;
          default: ;
        endcase
        if (pos_q[2:0] == cfrc_pkg::HdrPosCrcLo) begin
          final_en = 1'b1;
          if (!proc_ok_q) begin
            code = cfrc_pkg::RES_BAD_PROC;
          end else if (status_q != 8'h00) begin
            code = cfrc_pkg::RES_CAM_ERR;
          end else if (cmd_q != exp_cmd_i) begin
            code = cfrc_pkg::RES_CMD_MISMATCH;
          end else if (got != hdr_crc_q) begin
            code = cfrc_pkg::RES_HDR_CRC;
          end else begin
            final_en = 1'b0;
          end
        end
      end else if (pos_q < pay_end) begin
        crc_d      = crc_next;
        res_o.vld  = 1'b1;
        res_o.data = byte_i;
      end else if (pos_q == pay_end) begin
        crc_hi_d = byte_i;
      end else begin
        final_en = 1'b1;
        code     = (got == crc_q) ? cfrc_pkg::RES_OK : cfrc_pkg::RES_PKT_CRC;
      end

      if (final_en) begin
        res_o.vld  = 1'b1;
        res_o.last = 1'b1;
        res_o.code = code;
        res_o.cam  = (code == cfrc_pkg::RES_CAM_ERR) ? status_q : 8'h00;
        res_o.len  = (code == cfrc_pkg::RES_OK) ? len_q : 16'h0000;
        pos_d      = '0;
        proc_ok_d  = 1'b0;
        status_d   = '0;
        cmd_d      = '0;
        len_d      = '0;
        hdr_crc_d  = '0;
        crc_hi_d   = '0;
        crc_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      proc_ok_q <= 1'b0;
      status_q  <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      hdr_crc_q <= '0;
      crc_hi_q  <= '0;
      crc_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      proc_ok_q <= proc_ok_d;
      status_q  <= status_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      hdr_crc_q <= hdr_crc_d;
      crc_hi_q  <= crc_hi_d;
      crc_q     <= crc_d;
    end
  end

endmodule

// ===== design/cfrc_checker.sv =====
// ----------------------------------------------------------------------------
// cfrc_checker
// Port-level checks on the result beats of the framed response checker,
// attached to the top level by bind.
// ----------------------------------------------------------------------------
module cfrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  result_code_o,
  input logic [7:0]  camera_code_o,
  input logic [15:0] payload_length_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) &&
      $stable(result_code_o) && $stable(last_o) && $stable(payload_length_o))
    else $error("stalled result beat changed");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> result_code_o == cfrc_pkg::RES_OK &&
      camera_code_o == 8'h00 && payload_length_o == 16'h0000)
    else $error("payload beat carries status fields");

  a_err_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && result_code_o != cfrc_pkg::RES_OK |->
      payload_length_o == 16'h0000)
    else $error("error status reports a length");

  a_cam_only_on_cam_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_code_o != cfrc_pkg::RES_CAM_ERR |-> camera_code_o == 8'h00)
    else $error("camera code outside camera error");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_code_o <= cfrc_pkg::RES_PKT_CRC)
    else $error("result code out of range");

endmodule

bind crc_framed_response_checker cfrc_checker u_cfrc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .data_byte_o      (data_byte_o),
  .result_code_o    (result_code_o),
  .camera_code_o    (camera_code_o),
  .payload_length_o (payload_length_o),
  .last_o           (last_o)
);
